// ----- hdl/pme_pkg.sv -----
// Package for the polyline miter ribbon extruder: payload structs, queue job,
// back-end state codes, register indexes and the saturation/rounding helpers.
// No dependencies.
`default_nettype none
package pme_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SAT_BITS    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    localparam logic CFG_HALF_WIDTH = 1'b0;
    localparam logic CFG_Z_LIFT     = 1'b1;

    localparam logic [30:0] HALF_WIDTH_RST = 31'd65536;

    localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (SAT_BITS - 1)) - 36'sd1;
    localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               point_bad;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic signed [31:0] left_x;
        logic signed [31:0] left_y;
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] vertex_z;
        logic               last_pair;
    } t_res;

    typedef enum logic {JOB_SEG, JOB_FLUSH} t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic               first;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
        logic signed [31:0] hz;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } t_job;

    typedef enum logic [4:0] {
        S_IDLE, S_UMAG, S_USQX, S_USQY, S_USUM, S_SQRT,
        S_DIVX, S_DIVXW, S_DIVY, S_DIVYW, S_UDONE,
        S_CX, S_CY, S_CSUM, S_NDXW, S_NDY, S_NDYW,
        S_OFFX, S_OFFY, S_OFFR, S_EMIT
    } t_bstate;

    function automatic logic signed [31:0] sat_coord(input logic signed [35:0] v);
        logic signed [35:0] c;
        c = v;
        if (c > SAT_HI) c = SAT_HI;
        if (c < SAT_LO) c = SAT_LO;
        return c[31:0];
    endfunction

    // round half away from zero of prod / 2^16
    function automatic logic signed [34:0] round_off(input logic signed [63:0] prod);
        logic [63:0] mag;
        logic [63:0] q;
        mag = prod[63] ? 64'(-prod) : 64'(prod);
        q   = (mag + 64'h8000) >> 16;
        return prod[63] ? -$signed(q[34:0]) : $signed(q[34:0]);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/pme_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, 20-bit quotient.
// Depends on nothing; caller guarantees num < den * 2^20.
`default_nettype none
module pme_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [45:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [19:0]      o_quo
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [19:0] r_low, n_low;
    logic [19:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic [33:0] rem2;
    logic        ge;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quo  = r_quo;
        n_den  = r_den;
        rem2   = {r_rem, r_low[19]};
        ge     = rem2 >= {2'b00, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd19;
            n_rem  = {7'd0, i_num[45:20]};
            n_low  = i_num[19:0];
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? 33'(rem2 - {2'b00, r_den}) : rem2[32:0];
            n_low = {r_low[18:0], 1'b0};
            n_quo = {r_quo[18:0], ge};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_low <= n_low;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ----- hdl/pme_fifo.sv -----
// Short job queue between the front end and the back end.
// Depends on pme_pkg (t_job, Q_DEPTH).
`default_nettype none
module pme_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pme_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output pme_pkg::t_job      o_head
);
    pme_pkg::t_job r_mem [pme_pkg::Q_DEPTH];
    logic [pme_pkg::Q_PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [pme_pkg::Q_PTR_W:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp + pme_pkg::Q_PTR_W'(i_push);
        n_rp  = r_rp + pme_pkg::Q_PTR_W'(i_pop);
        n_cnt = r_cnt + (pme_pkg::Q_PTR_W + 1)'(i_push) - (pme_pkg::Q_PTR_W + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = r_cnt == (pme_pkg::Q_PTR_W + 1)'(pme_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];
endmodule
`default_nettype wire

// ----- hdl/pme_front.sv -----
// Front end: takes points, tracks truncation, duplicates and the held point,
// and posts segment and flush jobs. Depends on pme_pkg.
`default_nettype none
module pme_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire pme_pkg::t_point i_point,
    output logic                 o_q_push,
    output pme_pkg::t_job        o_q_job,
    input  wire logic            i_q_full
);
    logic signed [31:0] r_hx, n_hx, r_hy, n_hy, r_hz, n_hz;
    logic [1:0]         r_cc, n_cc;
    logic               r_trunc, n_trunc;
    logic               r_pend, n_pend;
    pme_pkg::t_job      r_pjob, n_pjob;
    logic               acc, dup, seg;
    pme_pkg::t_job      seg_job, fl_job;

    assign o_full = r_pend | i_q_full;

    always_comb begin
        n_hx = r_hx; n_hy = r_hy; n_hz = r_hz;
        n_cc = r_cc; n_trunc = r_trunc;
        n_pend = r_pend; n_pjob = r_pjob;
        o_q_push = 1'b0;
        acc = i_push & ~o_full;
        dup = (r_cc != 2'd0) && i_point.point_x == r_hx
              && i_point.point_y == r_hy && i_point.point_z == r_hz;
        seg = 1'b0;
        seg_job.kind  = pme_pkg::JOB_SEG;
        seg_job.first = r_cc == 2'd1;
        seg_job.hx    = r_hx;
        seg_job.hy    = r_hy;
        seg_job.hz    = r_hz;
        seg_job.dx    = 33'(i_point.point_x) - 33'(r_hx);
        seg_job.dy    = 33'(i_point.point_y) - 33'(r_hy);
        o_q_job = seg_job;
        if (acc && !r_trunc) begin
            if (i_point.point_bad) begin
                n_trunc = 1'b1;
            end else if (dup) begin
                n_cc = r_cc;
            end else if (r_cc == 2'd0) begin
                n_hx = i_point.point_x; n_hy = i_point.point_y; n_hz = i_point.point_z;
                n_cc = 2'd1;
            end else begin
                seg = 1'b1;
                o_q_push = 1'b1;
                n_hx = i_point.point_x; n_hy = i_point.point_y; n_hz = i_point.point_z;
                n_cc = 2'd2;
            end
        end
        fl_job       = seg_job;
        fl_job.kind  = pme_pkg::JOB_FLUSH;
        fl_job.first = 1'b0;
        fl_job.hx    = n_hx;
        fl_job.hy    = n_hy;
        fl_job.hz    = n_hz;
        if (acc && i_point.last_point) begin
            if (n_cc == 2'd2) begin
                if (seg) begin
                    n_pend = 1'b1;
                    n_pjob = fl_job;
                end else begin
                    o_q_push = 1'b1;
                    o_q_job  = fl_job;
                end
            end
            n_hx = '0; n_hy = '0; n_hz = '0;
            n_cc = 2'd0; n_trunc = 1'b0;
        end
        // second job of a point that both closes a segment and ends the line
        if (r_pend && !i_q_full) begin
            o_q_push = 1'b1;
            o_q_job  = r_pjob;
            n_pend   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx <= '0; r_hy <= '0; r_hz <= '0;
            r_cc <= 2'd0; r_trunc <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_hx <= n_hx; r_hy <= n_hy; r_hz <= n_hz;
            r_cc <= n_cc; r_trunc <= n_trunc; r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pjob <= n_pjob;
    end
endmodule
`default_nettype wire

// ----- hdl/pme_back.sv -----
// Back end: sequencer that normalizes directions (shared multiplier, bit-pair
// square root, iterative divider), builds miter normals and emits vertex pairs.
// Depends on pme_pkg and pme_div.
`default_nettype none
module pme_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire pme_pkg::t_job      i_q_head,
    output logic                    o_q_pop,
    input  wire logic [30:0]        i_half_width,
    input  wire logic signed [31:0] i_z_lift,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output pme_pkg::t_res           o_res
);
    pme_pkg::t_bstate   r_state, n_state;
    pme_pkg::t_job      r_job, n_job;
    logic signed [33:0] r_vx, n_vx, r_vy, n_vy;
    logic [30:0]        r_ax, n_ax, r_ay, n_ay;
    logic [62:0]        r_acc, n_acc, r_rad, n_rad;
    logic [63:0]        r_root, n_root;
    logic [4:0]         r_k, n_k;
    logic signed [15:0] r_ux, n_ux, r_uy, n_uy, r_ox, n_ox, r_oy, n_oy;
    logic signed [15:0] r_inx, n_inx, r_iny, n_iny, r_qx, n_qx, r_qy, n_qy;
    logic               r_pass, n_pass;
    logic signed [30:0] r_c, n_c;
    logic signed [20:0] r_nx, n_nx, r_ny, n_ny;
    logic signed [34:0] r_offx, n_offx, r_offy, n_offy;
    logic signed [63:0] r_prod;
    logic signed [33:0] mul_a, mul_b;
    logic               r_oval, n_oval;
    pme_pkg::t_res      r_out, n_out;

    logic [33:0]        mx, my;
    logic [63:0]        bitv, trial;
    logic               ge;
    logic signed [30:0] c_sum;
    logic [15:0]        qmag;
    logic signed [15:0] q16;
    logic               div_start, div_done;
    logic [45:0]        div_num;
    logic [31:0]        div_den;
    logic [19:0]        div_quo;

    pme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state; n_job = r_job; n_vx = r_vx; n_vy = r_vy;
        n_ax = r_ax; n_ay = r_ay; n_acc = r_acc; n_rad = r_rad; n_root = r_root;
        n_k = r_k; n_ux = r_ux; n_uy = r_uy; n_ox = r_ox; n_oy = r_oy;
        n_inx = r_inx; n_iny = r_iny; n_qx = r_qx; n_qy = r_qy; n_pass = r_pass;
        n_c = r_c; n_nx = r_nx; n_ny = r_ny; n_offx = r_offx; n_offy = r_offy;
        n_oval = r_oval & ~i_pop; n_out = r_out;
        o_q_pop = 1'b0;
        mul_a = '0; mul_b = '0;
        div_start = 1'b0; div_num = '0; div_den = '0;
        mx = r_vx[33] ? 34'(-r_vx) : 34'(r_vx);
        my = r_vy[33] ? 34'(-r_vy) : 34'(r_vy);
        bitv  = 64'd1 << {r_k, 1'b0};
        trial = r_root + bitv;
        ge    = {1'b0, r_rad} >= trial;
        c_sum = r_c + r_prod[30:0];
        qmag  = 16'(div_quo);
        q16   = $signed(qmag);
        case (r_state)
            pme_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_head;
                    if (i_q_head.kind == pme_pkg::JOB_FLUSH) begin
                        n_nx    = -21'(r_iny) * 21'sd4;
                        n_ny    = 21'(r_inx) * 21'sd4;
                        n_state = pme_pkg::S_OFFX;
                    end else begin
                        n_vx    = 34'(i_q_head.dx);
                        n_vy    = 34'(i_q_head.dy);
                        n_pass  = 1'b0;
                        n_state = pme_pkg::S_UMAG;
                    end
                end
            end
            pme_pkg::S_UMAG: begin
                if (mx == '0 && my == '0) begin
                    n_ux = '0; n_uy = '0;
                    n_state = pme_pkg::S_UDONE;
                end else begin
                    // halve both when either magnitude reaches 2^31
                    if (mx[31] || my[31]) begin
                        n_ax = mx[31:1]; n_ay = my[31:1];
                    end else begin
                        n_ax = mx[30:0]; n_ay = my[30:0];
                    end
                    n_state = pme_pkg::S_USQX;
                end
            end
            pme_pkg::S_USQX: begin
                mul_a = 34'(r_ax); mul_b = 34'(r_ax);
                n_state = pme_pkg::S_USQY;
            end
            pme_pkg::S_USQY: begin
                n_acc = r_prod[62:0];
                mul_a = 34'(r_ay); mul_b = 34'(r_ay);
                n_state = pme_pkg::S_USUM;
            end
            pme_pkg::S_USUM: begin
                n_rad  = r_acc + r_prod[62:0];
                n_root = '0;
                n_k    = 5'd31;
                n_state = pme_pkg::S_SQRT;
            end
            pme_pkg::S_SQRT: begin
                if (ge) begin
                    n_rad  = r_rad - trial[62:0];
                    n_root = (r_root >> 1) + bitv;
                end else begin
                    n_root = r_root >> 1;
                end
                n_k = r_k - 5'd1;
                if (r_k == 5'd0) n_state = pme_pkg::S_DIVX;
            end
            pme_pkg::S_DIVX: begin
                div_start = 1'b1;
                div_num = (46'(r_ax) << 14) + 46'(r_root[31:1]);
                div_den = r_root[31:0];
                n_state = pme_pkg::S_DIVXW;
            end
            pme_pkg::S_DIVXW: begin
                if (div_done) begin
                    n_ux = r_vx[33] ? -q16 : q16;
                    n_state = pme_pkg::S_DIVY;
                end
            end
            pme_pkg::S_DIVY: begin
                div_start = 1'b1;
                div_num = (46'(r_ay) << 14) + 46'(r_root[31:1]);
                div_den = r_root[31:0];
                n_state = pme_pkg::S_DIVYW;
            end
            pme_pkg::S_DIVYW: begin
                if (div_done) begin
                    n_uy = r_vy[33] ? -q16 : q16;
                    n_state = pme_pkg::S_UDONE;
                end
            end
            pme_pkg::S_UDONE: begin
                if (!r_pass) begin
                    n_ox = r_ux; n_oy = r_uy;
                    if (r_job.first) begin
                        n_nx  = -21'(r_uy) * 21'sd4;
                        n_ny  = 21'(r_ux) * 21'sd4;
                        n_inx = r_ux; n_iny = r_uy;
                        n_state = pme_pkg::S_OFFX;
                    end else begin
                        // sum of incoming and outgoing perpendiculars
                        n_vx   = -34'(r_iny) - 34'(r_uy);
                        n_vy   = 34'(r_inx) + 34'(r_ux);
                        n_pass = 1'b1;
                        n_state = pme_pkg::S_UMAG;
                    end
                end else begin
                    // exact reversal: fall back to the incoming perpendicular
                    if (r_ux == '0 && r_uy == '0) begin
                        n_qx = -r_iny; n_qy = r_inx;
                    end else begin
                        n_qx = r_ux; n_qy = r_uy;
                    end
                    n_state = pme_pkg::S_CX;
                end
            end
            pme_pkg::S_CX: begin
                mul_a = 34'(r_qx); mul_b = -34'(r_iny);
                n_state = pme_pkg::S_CY;
            end
            pme_pkg::S_CY: begin
                n_c = r_prod[30:0];
                mul_a = 34'(r_qy); mul_b = 34'(r_inx);
                n_state = pme_pkg::S_CSUM;
            end
            pme_pkg::S_CSUM: begin
                n_c = c_sum;
                n_inx = r_ox; n_iny = r_oy;
                if (c_sum >= 31'sd67108864) begin
                    div_start = 1'b1;
                    div_num = (46'(r_qx[15] ? -r_qx : r_qx) << 30) + 46'(c_sum[30:1]);
                    div_den = 32'(c_sum);
                    n_state = pme_pkg::S_NDXW;
                end else begin
                    n_nx = 21'(r_qx) * 21'sd16;
                    n_ny = 21'(r_qy) * 21'sd16;
                    n_state = pme_pkg::S_OFFX;
                end
            end
            pme_pkg::S_NDXW: begin
                if (div_done) begin
                    n_nx = r_qx[15] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                    n_state = pme_pkg::S_NDY;
                end
            end
            pme_pkg::S_NDY: begin
                div_start = 1'b1;
                div_num = (46'(r_qy[15] ? -r_qy : r_qy) << 30) + 46'(r_c[30:1]);
                div_den = 32'(r_c);
                n_state = pme_pkg::S_NDYW;
            end
            pme_pkg::S_NDYW: begin
                if (div_done) begin
                    n_ny = r_qy[15] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                    n_state = pme_pkg::S_OFFX;
                end
            end
            pme_pkg::S_OFFX: begin
                mul_a = 34'(r_nx); mul_b = 34'(i_half_width);
                n_state = pme_pkg::S_OFFY;
            end
            pme_pkg::S_OFFY: begin
                n_offx = pme_pkg::round_off(r_prod);
                mul_a = 34'(r_ny); mul_b = 34'(i_half_width);
                n_state = pme_pkg::S_OFFR;
            end
            pme_pkg::S_OFFR: begin
                n_offy = pme_pkg::round_off(r_prod);
                n_state = pme_pkg::S_EMIT;
            end
            pme_pkg::S_EMIT: begin
                if (!r_oval || i_pop) begin
                    n_oval = 1'b1;
                    n_out.left_x   = pme_pkg::sat_coord(36'(r_job.hx) - 36'(r_offx));
                    n_out.left_y   = pme_pkg::sat_coord(36'(r_job.hy) - 36'(r_offy));
                    n_out.right_x  = pme_pkg::sat_coord(36'(r_job.hx) + 36'(r_offx));
                    n_out.right_y  = pme_pkg::sat_coord(36'(r_job.hy) + 36'(r_offy));
                    n_out.vertex_z = pme_pkg::sat_coord(36'(r_job.hz) + 36'(i_z_lift));
                    n_out.last_pair = r_job.kind == pme_pkg::JOB_FLUSH;
                    n_state = pme_pkg::S_IDLE;
                end
            end
            default: n_state = pme_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pme_pkg::S_IDLE;
            r_oval  <= 1'b0;
            r_inx   <= '0;
            r_iny   <= '0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
            r_inx   <= n_inx;
            r_iny   <= n_iny;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_vx <= n_vx; r_vy <= n_vy; r_ax <= n_ax; r_ay <= n_ay;
        r_acc <= n_acc; r_rad <= n_rad; r_root <= n_root; r_k <= n_k;
        r_ux <= n_ux; r_uy <= n_uy; r_ox <= n_ox; r_oy <= n_oy;
        r_qx <= n_qx; r_qy <= n_qy; r_pass <= n_pass; r_c <= n_c;
        r_nx <= n_nx; r_ny <= n_ny; r_offx <= n_offx; r_offy <= n_offy;
        r_out <= n_out;
        r_prod <= 64'(mul_a * mul_b);
    end

    assign o_empty = ~r_oval;
    assign o_res   = r_out;
endmodule
`default_nettype wire

// ----- hdl/polyline_miter_ribbon_extrude.sv -----
// Top level of the polyline miter ribbon extruder: configuration registers,
// front end, job queue and back end. Depends on pme_pkg, pme_front, pme_fifo,
// pme_back (and pme_div through it).
//
// Points go in one per request through a queue-style push/full port and
// vertex pairs come out through an empty/pop port; each result request holds
// the left and right vertex of one clean point, the shared z plus lift, and a
// flag on the pair of the line's final point. The front end accepts a point
// per cycle while the job queue has room; a point that posts two jobs keeps
// full high until its second job is queued. It handles bad-point truncation,
// duplicate dropping and the one-point lookahead, and posts a segment job
// (point closes a segment) and/or a flush job (line end). The back end works
// one job at a time, and a job can also wait for the result register to be
// popped. Its work is set by the 32-step bit-pair square root and the
// iterative divider: the root and two divisions run once per direction
// normalization (once for an end point, twice for an inner point, not at all
// when a direction has no xy extent), plus two more divisions for the miter
// scale unless it clamps; a flush job needs none of them.
// A four-entry queue lets the front end keep taking points while the back
// end is busy, and a result register lets the back end finish the next job
// while a pair waits to be popped. Configuration (half width, z lift) is
// written through a plain write port; the user must write it only while the
// block is idle, and the block itself does not enforce this. Both values of
// the one-bit index select a register.
`default_nettype none
module polyline_miter_ribbon_extrude (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire pme_pkg::t_point i_point,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output pme_pkg::t_res        o_res,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [31:0]     i_cfg_wdata
);
    logic [30:0]        r_half_width;
    logic signed [31:0] r_z_lift;
    logic               q_push, q_full, q_pop, q_empty;
    pme_pkg::t_job      q_job, q_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= pme_pkg::HALF_WIDTH_RST;
            r_z_lift     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pme_pkg::CFG_HALF_WIDTH: r_half_width <= i_cfg_wdata[30:0];
                pme_pkg::CFG_Z_LIFT:     r_z_lift     <= $signed(i_cfg_wdata);
                default: r_z_lift <= r_z_lift;
            endcase
        end
    end

    pme_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_point  (i_point),
        .o_q_push (q_push),
        .o_q_job  (q_job),
        .i_q_full (q_full)
    );

    pme_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pme_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .i_half_width (r_half_width),
        .i_z_lift     (r_z_lift),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_res        (o_res)
    );

`ifndef SYNTHESIS
    // front end never posts a job into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("job queue overflow");
    // back end never takes a job from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("job queue underflow");
    // a queue that stays full keeps the input port full
    a_full_after_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && !q_pop) |=> o_full) else $error("full not raised with queue full");
`endif
endmodule
`default_nettype wire

// ----- test/polyline_miter_ribbon_extrude_test.sv -----
// Self-checking testbench for polyline_miter_ribbon_extrude: random and directed
// polylines through the push/full port, vertex pairs checked on the empty/pop port.
// Depends on pme_pkg and the block's RTL.
module polyline_miter_ribbon_extrude_test;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_push = 1'b0;
    logic             o_full;
    pme_pkg::t_point  i_point = '0;
    logic             o_empty;
    logic             i_pop = 1'b0;
    pme_pkg::t_res    o_res;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = pme_pkg::CFG_HALF_WIDTH;
    logic [31:0]      i_cfg_wdata = '0;

    polyline_miter_ribbon_extrude i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_point     (i_point),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Points waiting to be pushed, pairs waiting to be popped.
    pme_pkg::t_point point_queue[$];
    pme_pkg::t_res   pending_pairs[$];
    int     mismatches = 0;
    int     points_queued = 0;
    bit     calm = 1'b0;        // no idling on either side while set
    int     push_gap = 0;
    int     pop_stall = 0;
    int     quiet_cycles = 0;

    // Predictor state: configuration copy and line state.
    longint hw_cfg = 65536;
    longint lift_cfg = 0;
    longint held_x = 0, held_y = 0, held_z = 0;
    longint in_dir_x = 0, in_dir_y = 0;
    int     kept_count = 0;
    bit     cut_off = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;  // covers a point-less flush still in the back end

    // ---------------------------------------------------------------- predictor

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit vector in Q1.14; zero vector stays zero.
    task automatic unit_dir(input longint dx, input longint dy,
                            output longint ux, output longint uy);
        longint unsigned ax, ay, len, qx, qy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax == 0 && ay == 0) begin
            ux = 0;
            uy = 0;
            return;
        end
        if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        qx = ((ax << 14) + len / 2) / len;
        qy = ((ay << 14) + len / 2) / len;
        ux = (dx < 0) ? -longint'(qx) : longint'(qx);
        uy = (dy < 0) ? -longint'(qy) : longint'(qy);
    endtask

    function automatic longint div_half_away(longint num, longint den);
        longint q;
        q = (((num < 0) ? -num : num) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint offset_of(longint n16);
        longint prod, q;
        prod = n16 * hw_cfg;
        q = (((prod < 0) ? -prod : prod) + 32768) >>> 16;
        return (prod < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp_coord(longint v);
        longint top, bot;
        top = (64'sd1 <<< (pme_pkg::SAT_BITS - 1)) - 1;
        bot = -top - 1;
        if (v > top) v = top;
        if (v < bot) v = bot;
        return v[31:0];
    endfunction

    function automatic pme_pkg::t_res vertex_pair(longint nx, longint ny, bit fin);
        pme_pkg::t_res r;
        longint ox, oy;
        ox = offset_of(nx);
        oy = offset_of(ny);
        r.left_x    = clamp_coord(held_x - ox);
        r.left_y    = clamp_coord(held_y - oy);
        r.right_x   = clamp_coord(held_x + ox);
        r.right_y   = clamp_coord(held_y + oy);
        r.vertex_z  = clamp_coord(held_z + lift_cfg);
        r.last_pair = fin;
        return r;
    endfunction

    // Miter normal (Q4.16) at an inner point, from outgoing direction ox, oy.
    task automatic miter_normal(input longint ox, input longint oy,
                                output longint nx, output longint ny);
        longint px, py, ax, ay, c;
        px = -in_dir_y;
        py = in_dir_x;
        unit_dir(px - oy, py + ox, ax, ay);
        // exact reversal: the sum vanishes, fall back to incoming perpendicular
        if (ax == 0 && ay == 0) begin
            ax = px;
            ay = py;
        end
        c = ax * px + ay * py;
        if (c >= (64'sd1 <<< 26)) begin
            nx = div_half_away(ax * (64'sd1 <<< 30), c);
            ny = div_half_away(ay * (64'sd1 <<< 30), c);
        end else begin
            // turn too sharp: miter scale clamped at 4
            nx = ax * 16;
            ny = ay * 16;
        end
    endtask

    // Advance the line state by one accepted point; queue the pairs it causes.
    task automatic predict_point(input pme_pkg::t_point p);
        longint x, y, z, dx, dy, nx, ny;
        x = p.point_x;
        y = p.point_y;
        z = p.point_z;
        if (!cut_off && p.point_bad) begin
            cut_off = 1'b1;
        end else if (!cut_off) begin
            if (kept_count > 0 && x == held_x && y == held_y && z == held_z) begin
                // duplicate: dropped
            end else if (kept_count == 0) begin
                held_x = x;
                held_y = y;
                held_z = z;
                kept_count = 1;
            end else begin
                unit_dir(x - held_x, y - held_y, dx, dy);
                if (kept_count == 1) begin
                    nx = -dy * 4;
                    ny = dx * 4;
                end else begin
                    miter_normal(dx, dy, nx, ny);
                end
                pending_pairs.insert(pending_pairs.size(), vertex_pair(nx, ny, 1'b0));
                in_dir_x = dx;
                in_dir_y = dy;
                held_x = x;
                held_y = y;
                held_z = z;
                kept_count = 2;
            end
        end
        if (p.last_point) begin
            if (kept_count >= 2)
                pending_pairs.insert(pending_pairs.size(),
                                     vertex_pair(-in_dir_y * 4, in_dir_x * 4, 1'b1));
            held_x = 0;
            held_y = 0;
            held_z = 0;
            in_dir_x = 0;
            in_dir_y = 0;
            kept_count = 0;
            cut_off = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- driver side

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Push side: keep a request up until taken, then maybe pause.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (!i_push || !o_full) begin
            if (push_gap > 0) begin
                push_gap <= push_gap - 1;
                i_push <= 1'b0;
            end else if (point_queue.size() > 0) begin
                i_point <= point_queue.pop_front();
                i_push <= 1'b1;
                push_gap <= pick_gap();
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Pop side: stall at random, now and then for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
            pop_stall <= pick_gap();
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: predict on accepted points, compare accepted pairs, watchdog.
    always @(posedge i_clk) begin
        pme_pkg::t_res want;
        if (i_rst_n) begin
            if (i_push && !o_full) predict_point(i_point);
            if (i_pop && !o_empty) begin
                if (pending_pairs.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected pair, expected none actual %h", $time, o_res);
                end else begin
                    want = pending_pairs.pop_front();
                    check_field("left_x", want.left_x, o_res.left_x);
                    check_field("left_y", want.left_y, o_res.left_y);
                    check_field("right_x", want.right_x, o_res.right_x);
                    check_field("right_y", want.right_y, o_res.right_y);
                    check_field("vertex_z", want.vertex_z, o_res.vertex_z);
                    check_field("last_pair", want.last_pair, o_res.last_pair);
                end
            end
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic pme_pkg::t_point mk_point(int x, int y, int z, bit bad, bit fin);
        pme_pkg::t_point p;
        p.point_x    = x;
        p.point_y    = y;
        p.point_z    = z;
        p.point_bad  = bad;
        p.last_point = fin;
        return p;
    endfunction

    task automatic add_point(input pme_pkg::t_point p);
        point_queue.insert(point_queue.size(), p);
        points_queued++;
    endtask

    // Registers only change with nothing in flight, so the model copy follows at once.
    task automatic write_reg(input logic idx, input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pme_pkg::CFG_HALF_WIDTH) hw_cfg = v[30:0];
        else lift_cfg = longint'($signed(v));
    endtask

    task automatic drain();
        while (point_queue.size() > 0 || i_push || pending_pairs.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random line: mostly well-formed walks, with duplicates, reversals,
    // zero-extent segments, bad points and stray line ends mixed in.
    task automatic add_random_line();
        int n, r, step;
        int x, y, z, px, py, pz;
        bit wide, bad, fin;
        n = $urandom_range(1, 8);
        wide = ($urandom_range(0, 9) == 0);
        x = $urandom;
        y = $urandom;
        z = $urandom;
        if (!wide && $urandom_range(0, 3) != 0) begin
            x = x >>> 8;
            y = y >>> 8;
        end
        px = x;
        py = y;
        pz = z;
        for (int i = 0; i < n; i++) begin
            bad = ($urandom_range(0, 99) < 3);
            fin = (i == n - 1) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 99) < 2);
            add_point(mk_point(x, y, z, bad, fin));
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // repeat: exact duplicate
            end else if (r < 14 && i > 0) begin
                // back to the previous point: exact reversal
                {x, px} = {px, x};
                {y, py} = {py, y};
                {z, pz} = {pz, z};
            end else if (r < 19) begin
                px = x;
                py = y;
                pz = z;
                z = z + $urandom_range(1, 1000);
            end else begin
                px = x;
                py = y;
                pz = z;
                if (wide) begin
                    x = $urandom;
                    y = $urandom;
                end else begin
                    step = $urandom_range(2, 22);
                    x = x + ($signed($urandom) >>> (32 - step));
                    y = y + ($signed($urandom) >>> (32 - step));
                end
                z = ($urandom_range(0, 1) == 0) ? z : int'($urandom);
            end
        end
    endtask

    initial begin
        int target;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset half width, then again at the extremes.
        calm = 1'b1;
        write_reg(pme_pkg::CFG_HALF_WIDTH, 32'd65536);
        write_reg(pme_pkg::CFG_Z_LIFT, 32'd0);
        for (int pass = 0; pass < 2; pass++) begin
            // plain right-angle line through three points
            add_point(mk_point(0, 0, 0, 0, 0));
            add_point(mk_point(32'h000a0000, 0, 5, 0, 0));
            add_point(mk_point(32'h000a0000, 32'h000a0000, 7, 0, 1));
            // duplicate dropped, reversal, duplicate carrying the line end
            add_point(mk_point(100, 200, 300, 0, 0));
            add_point(mk_point(100, 200, 300, 0, 0));
            add_point(mk_point(90000, 200, 300, 0, 0));
            add_point(mk_point(100, 200, 300, 0, 0));
            add_point(mk_point(100, 200, 300, 0, 1));
            // lone point: nothing out
            add_point(mk_point(5, 5, 5, 0, 1));
            // bad point truncates; later points ignored, their end still flushes
            add_point(mk_point(1, 2, 3, 0, 0));
            add_point(mk_point(70000, 2, 3, 0, 0));
            add_point(mk_point(0, 0, 0, 1, 0));
            add_point(mk_point(9, 9, 9, 0, 1));
            // zero xy extent segment, then extremes of the coordinate range
            add_point(mk_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0));
            add_point(mk_point(32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0));
            add_point(mk_point(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0));
            add_point(mk_point(32'h7fffffff, 32'h7fffffff, 0, 0, 1));
            // sharp turn: miter clamp
            add_point(mk_point(0, 0, 0, 0, 0));
            add_point(mk_point(32'h00100000, 0, 0, 0, 0));
            add_point(mk_point(0, 32'h00010000, 0, 0, 1));
            drain();
            if (pass == 0) begin
                write_reg(pme_pkg::CFG_HALF_WIDTH, 32'h7fffffff);
                write_reg(pme_pkg::CFG_Z_LIFT, 32'h7fffffff);
            end
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(pme_pkg::CFG_HALF_WIDTH, 32'd0);
                    write_reg(pme_pkg::CFG_Z_LIFT, 32'h80000000);
                end
                1: begin
                    write_reg(pme_pkg::CFG_HALF_WIDTH, 32'h7fffffff);
                    write_reg(pme_pkg::CFG_Z_LIFT, 32'h7fffffff);
                end
                default: begin
                    write_reg(pme_pkg::CFG_HALF_WIDTH, $urandom_range(0, 3) == 0 ?
                              $urandom : $urandom_range(0, 32'h00100000));
                    write_reg(pme_pkg::CFG_Z_LIFT, $urandom);
                end
            endcase
            calm = (ph == 3);
            target = points_queued + 265;
            while (points_queued < target) add_random_line();
            // close any line left open so its held point is flushed
            add_point(mk_point(0, 0, 0, 1, 1));
            drain();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/pme_pkg.sv
hdl/pme_div.sv
hdl/pme_fifo.sv
hdl/pme_front.sv
hdl/pme_back.sv
hdl/polyline_miter_ribbon_extrude.sv
test/polyline_miter_ribbon_extrude_test.sv
